>>> rtl/core/assert_macros.svh
// Assertion macros shared by the row span rasterizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted
`define TRSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also holds during reset
`define TRSR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

>>> rtl/core/trsr_pkg.sv
// Package for the triangle row span rasterizer: constants, register codes,
// microcode word layout and the microcode program table. No dependencies.
`default_nettype none

package trsr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_V0X   = 3'd0,
        REG_V0Y   = 3'd1,
        REG_V1X   = 3'd2,
        REG_V1Y   = 3'd3,
        REG_V2X   = 3'd4,
        REG_V2Y   = 3'd5,
        REG_COLOR = 3'd6
    } t_reg_idx;

    // Microcode step address
    localparam int UPC_BITS = 4;
    typedef logic [UPC_BITS-1:0] t_upc;

    localparam t_upc UPC_WAIT  = 4'd0;
    localparam t_upc UPC_CHECK = 4'd1;
    localparam t_upc UPC_MUL1  = 4'd2;
    localparam t_upc UPC_MUL2  = 4'd3;
    localparam t_upc UPC_MUL3  = 4'd4;
    localparam t_upc UPC_MUL4  = 4'd5;
    localparam t_upc UPC_MUL5  = 4'd6;
    localparam t_upc UPC_ACC5  = 4'd7;
    localparam t_upc UPC_SCAN  = 4'd8;
    localparam t_upc UPC_EMIT  = 4'd9;
    localparam t_upc UPC_LAST  = UPC_EMIT;

    // Product term select: bits [2:1] pick the edge, bit 0 the y-term
    typedef logic [2:0] t_term;

    localparam t_term TERM_E0_X = 3'd0;
    localparam t_term TERM_E0_Y = 3'd1;
    localparam t_term TERM_E1_X = 3'd2;
    localparam t_term TERM_E1_Y = 3'd3;
    localparam t_term TERM_E2_X = 3'd4;
    localparam t_term TERM_E2_Y = 3'd5;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS  = 3'd0,
        C_IN_FIRE = 3'd1,
        C_SKIP    = 3'd2,
        C_LAST    = 3'd3,
        C_EMIT_OK = 3'd4
    } t_cond;

    // One control word
    typedef struct packed {
        logic  ready;     // input channel may take an item
        logic  mul_en;    // register a product
        t_term mul_sel;
        logic  acc_en;    // fold the registered product into an edge
        t_term acc_sel;
        logic  scan_en;   // evaluate one column and step
        logic  emit_en;   // load the output register
        t_cond cond;
        logic  hold;      // stay on this step when cond is false
        t_upc  tgt;       // jump target when cond is true
    } t_uword;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic row_skip;
        logic last_col;
        logic emit_ok;
    } t_status;

    // Microcode program
    function automatic t_uword ucode_rom(input t_upc a);
        t_uword w;
        w      = '0;
        w.cond = C_ALWAYS;
        w.tgt  = UPC_WAIT;
        unique case (a)
            UPC_WAIT: begin
                w.ready = 1'b1;
                w.cond  = C_IN_FIRE;
                w.hold  = 1'b1;
                w.tgt   = UPC_CHECK;
            end
            UPC_CHECK: begin
                w.mul_en  = 1'b1;
                w.mul_sel = TERM_E0_X;
                w.cond    = C_SKIP;
                w.tgt     = UPC_EMIT;
            end
            UPC_MUL1: begin
                w.mul_en = 1'b1; w.mul_sel = TERM_E0_Y;
                w.acc_en = 1'b1; w.acc_sel = TERM_E0_X;
                w.cond   = C_SKIP; w.tgt = UPC_EMIT;
            end
            UPC_MUL2: begin
                w.mul_en = 1'b1; w.mul_sel = TERM_E1_X;
                w.acc_en = 1'b1; w.acc_sel = TERM_E0_Y;
                w.tgt    = UPC_MUL3;
            end
            UPC_MUL3: begin
                w.mul_en = 1'b1; w.mul_sel = TERM_E1_Y;
                w.acc_en = 1'b1; w.acc_sel = TERM_E1_X;
                w.tgt    = UPC_MUL4;
            end
            UPC_MUL4: begin
                w.mul_en = 1'b1; w.mul_sel = TERM_E2_X;
                w.acc_en = 1'b1; w.acc_sel = TERM_E1_Y;
                w.tgt    = UPC_MUL5;
            end
            UPC_MUL5: begin
                w.mul_en = 1'b1; w.mul_sel = TERM_E2_Y;
                w.acc_en = 1'b1; w.acc_sel = TERM_E2_X;
                w.tgt    = UPC_ACC5;
            end
            UPC_ACC5: begin
                w.acc_en = 1'b1; w.acc_sel = TERM_E2_Y;
                w.tgt    = UPC_SCAN;
            end
            UPC_SCAN: begin
                w.scan_en = 1'b1;
                w.cond    = C_LAST;
                w.hold    = 1'b1;
                w.tgt     = UPC_EMIT;
            end
            UPC_EMIT: begin
                w.emit_en = 1'b1;
                w.cond    = C_EMIT_OK;
                w.hold    = 1'b1;
                w.tgt     = UPC_WAIT;
            end
            default: begin
                w.tgt = UPC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/trsr_in_if.sv
// Input channel of the row span rasterizer: one row number per item.
// Depends on nothing but its coordinate width parameter.
`default_nettype none

interface trsr_in_if #(
    parameter int CB = 10
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] row_y;

    modport source (output valid, output row_y, input ready);
    modport sink   (input valid, input row_y, output ready);
endinterface

`default_nettype wire

>>> rtl/core/trsr_out_if.sv
// Output channel of the row span rasterizer: one span result per item.
// Depends on trsr_pkg for the color width.
`default_nettype none

interface trsr_out_if #(
    parameter int CB = 10
);
    import trsr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [CB-1:0]         span_start;
    logic [CB-1:0]         span_end;
    logic [CB-1:0]         row_out;
    logic [COLOR_BITS-1:0] pixel_color;

    modport source (output valid, output hit, output span_start, output span_end,
                    output row_out, output pixel_color, input ready);
    modport sink   (input valid, input hit, input span_start, input span_end,
                    input row_out, input pixel_color, output ready);
endinterface

`default_nettype wire

>>> rtl/core/trsr_sequencer.sv
// Microcode sequencer: step counter, program table lookup, conditional jumps.
// Depends on trsr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module trsr_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trsr_pkg::t_status i_status,
    output trsr_pkg::t_uword  o_ctl
);
    import trsr_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_ctl;
    logic   w_take;

    // Fetch and next-step select
    always_comb begin
        w_ctl = ucode_rom(r_upc);
        unique case (w_ctl.cond)
            C_ALWAYS:  w_take = 1'b1;
            C_IN_FIRE: w_take = i_status.in_fire;
            C_SKIP:    w_take = i_status.row_skip;
            C_LAST:    w_take = i_status.last_col;
            C_EMIT_OK: w_take = i_status.emit_ok;
            default:   w_take = 1'b0;
        endcase
        if (w_take) begin
            n_upc = w_ctl.tgt;
        end else if (w_ctl.hold) begin
            n_upc = r_upc;
        end else begin
            n_upc = t_upc'(r_upc + 1'b1);
        end
    end

    assign o_ctl = w_ctl;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Counter is unknown until the first reset edge, so only checked once reset is seen
    `TRSR_ASSERT(a_fire_to_check, i_clk, i_rst_n, i_status.in_fire |=> r_upc == UPC_CHECK, "accepted item did not start setup")
    `TRSR_ASSERT_NR(a_upc_in_program, i_clk, !i_rst_n || (r_upc <= UPC_LAST), "step counter left the program")

endmodule

`default_nettype wire

>>> rtl/core/trsr_datapath.sv
// Rasterizer datapath: bounding box, shared multiplier for edge setup,
// incremental column scan, span tracking and the output register.
// Depends on trsr_pkg, trsr_in_if, trsr_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module trsr_datapath #(
    parameter int CB = trsr_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [CB-1:0]                   i_vx [3],
    input  logic [CB-1:0]                   i_vy [3],
    input  logic [trsr_pkg::COLOR_BITS-1:0] i_color,
    input  trsr_pkg::t_uword                i_ctl,
    output trsr_pkg::t_status               o_status,
    trsr_in_if.sink                         i_row,
    trsr_out_if.source                      o_span
);
    import trsr_pkg::*;

    localparam int DW = CB + 1;       // coordinate difference
    localparam int EW = 2 * CB + 2;   // edge function value

    function automatic logic [CB-1:0] min3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                           input logic [CB-1:0] c);
        logic [CB-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [CB-1:0] max3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                           input logic [CB-1:0] c);
        logic [CB-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic signed [DW-1:0] sdiff(input logic [CB-1:0] a,
                                                   input logic [CB-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    logic [CB-1:0]          w_xmin, w_xmax, w_ymin, w_ymax;
    logic [CB-1:0]          w_xa, w_ya, w_xb, w_yb;
    logic signed [DW-1:0]   w_ma, w_mb;
    logic signed [EW-1:0]   w_prod;
    logic signed [DW-1:0]   w_dy [3];
    logic                   w_covered;
    logic                   w_in_fire;
    logic                   w_emit_ok;

    logic [CB-1:0]          r_y;
    logic [CB-1:0]          r_x;
    logic signed [EW-1:0]   r_prod;
    logic signed [EW-1:0]   r_edge [3];
    logic                   r_hit;
    logic [CB-1:0]          r_first, r_last;

    logic                   r_ov;
    logic                   r_o_hit;
    logic [CB-1:0]          r_o_start, r_o_end, r_o_row;
    logic [COLOR_BITS-1:0]  r_o_color;

    // Bounding box
    assign w_xmin = min3(i_vx[0], i_vx[1], i_vx[2]);
    assign w_xmax = max3(i_vx[0], i_vx[1], i_vx[2]);
    assign w_ymin = min3(i_vy[0], i_vy[1], i_vy[2]);
    assign w_ymax = max3(i_vy[0], i_vy[1], i_vy[2]);

    // Edge endpoints for the selected product term
    always_comb begin
        case (i_ctl.mul_sel[2:1])
            2'd0: begin
                w_xa = i_vx[0]; w_ya = i_vy[0]; w_xb = i_vx[1]; w_yb = i_vy[1];
            end
            2'd1: begin
                w_xa = i_vx[1]; w_ya = i_vy[1]; w_xb = i_vx[2]; w_yb = i_vy[2];
            end
            default: begin
                w_xa = i_vx[2]; w_ya = i_vy[2]; w_xb = i_vx[0]; w_yb = i_vy[0];
            end
        endcase
    end

    // Shared multiplier operands: (x - xa)*(yb - ya) or (y - ya)*(xb - xa)
    assign w_ma   = i_ctl.mul_sel[0] ? sdiff(r_y, w_ya) : sdiff(r_x, w_xa);
    assign w_mb   = i_ctl.mul_sel[0] ? sdiff(w_xb, w_xa) : sdiff(w_yb, w_ya);
    assign w_prod = EW'(w_ma) * EW'(w_mb);

    // Per-column step of each edge
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dy[k] = sdiff(i_vy[(k + 1) % 3], i_vy[k]);
        end
    end

    assign w_covered = !r_edge[0][EW-1] && !r_edge[1][EW-1] && !r_edge[2][EW-1];

    // Handshakes and status
    assign w_in_fire    = i_row.valid && i_ctl.ready;
    assign w_emit_ok    = !r_ov || o_span.ready;
    assign i_row.ready  = i_ctl.ready;

    assign o_status.in_fire  = w_in_fire;
    assign o_status.row_skip = !((r_y >= w_ymin) && (r_y < w_ymax)) || !(w_xmin < w_xmax);
    assign o_status.last_col = (({1'b0, r_x} + 1'b1) == {1'b0, w_xmax});
    assign o_status.emit_ok  = w_emit_ok;

    // Row, column and edge registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_y <= i_row.row_y;
            r_x <= w_xmin;
        end else if (i_ctl.scan_en) begin
            r_x <= r_x + 1'b1;
        end

        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end

        for (int k = 0; k < 3; k++) begin
            if (i_ctl.acc_en && (i_ctl.acc_sel[2:1] == 2'(k))) begin
                r_edge[k] <= i_ctl.acc_sel[0] ? (r_edge[k] - r_prod) : r_prod;
            end else if (i_ctl.scan_en) begin
                r_edge[k] <= r_edge[k] + EW'(w_dy[k]);
            end
        end
    end

    // Span tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else if (w_in_fire) begin
            r_hit   <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else if (i_ctl.scan_en && w_covered) begin
            r_hit  <= 1'b1;
            r_last <= r_x;
            if (!r_hit) begin
                r_first <= r_x;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.emit_en && w_emit_ok) begin
            r_ov <= 1'b1;
        end else if (o_span.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_en && w_emit_ok) begin
            r_o_hit   <= r_hit;
            r_o_start <= r_first;
            r_o_end   <= r_last;
            r_o_row   <= r_y;
            r_o_color <= r_hit ? i_color : '0;
        end
    end

    assign o_span.valid       = r_ov;
    assign o_span.hit         = r_o_hit;
    assign o_span.span_start  = r_o_start;
    assign o_span.span_end    = r_o_end;
    assign o_span.row_out     = r_o_row;
    assign o_span.pixel_color = r_o_color;

    `TRSR_ASSERT(a_scan_in_box, i_clk, i_rst_n, i_ctl.scan_en |-> (r_x >= w_xmin) && (r_x < w_xmax), "scan column outside bounding box")
    `TRSR_ASSERT(a_span_order, i_clk, i_rst_n, r_hit |-> (r_first <= r_last), "span start beyond span end")

endmodule

`default_nettype wire

>>> rtl/core/triangle_row_span_rasterizer.sv
// Top level of the triangle row span rasterizer: configuration registers,
// microcode sequencer and datapath.
// Depends on trsr_pkg, trsr_in_if, trsr_out_if, trsr_sequencer, trsr_datapath.
//
//  channel   dir  payload                                          accepted when
//  i_row     in   row_y                                            valid & ready
//  o_span    out  hit, span_start, span_end, row_out, pixel_color  valid & ready
//  i_cfg_*   in   i_cfg_idx, i_cfg_data                            i_cfg_we
//
// A row inside the bounding box passes one accept step, seven setup steps
// through the single shared multiplier (six products), one step per column
// (W = xmax - xmin columns) and one emit step before the next ready.
// A row outside the box, or an empty box, goes from the check step to emit.
// The input is taken only on the wait step; the output register holds one
// finished result, and the emit step holds while it is full and unread.
// Reset is synchronous and active low; it clears configuration to zero.
`default_nettype none

module triangle_row_span_rasterizer #(
    parameter int COORD_BITS = trsr_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [trsr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [trsr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    trsr_in_if.sink                            i_row,
    trsr_out_if.source                         o_span
);
    import trsr_pkg::*;

    logic [COORD_BITS-1:0] r_vx [3];
    logic [COORD_BITS-1:0] r_vy [3];
    logic [COLOR_BITS-1:0] r_color;

    t_uword  w_ctl;
    t_status w_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
            r_color <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_V0X:   r_vx[0] <= i_cfg_data[COORD_BITS-1:0];
                REG_V0Y:   r_vy[0] <= i_cfg_data[COORD_BITS-1:0];
                REG_V1X:   r_vx[1] <= i_cfg_data[COORD_BITS-1:0];
                REG_V1Y:   r_vy[1] <= i_cfg_data[COORD_BITS-1:0];
                REG_V2X:   r_vx[2] <= i_cfg_data[COORD_BITS-1:0];
                REG_V2Y:   r_vy[2] <= i_cfg_data[COORD_BITS-1:0];
                REG_COLOR: r_color <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    trsr_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctl    (w_ctl)
    );

    trsr_datapath #(
        .CB (COORD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vx     (r_vx),
        .i_vy     (r_vy),
        .i_color  (r_color),
        .i_ctl    (w_ctl),
        .o_status (w_status),
        .i_row    (i_row),
        .o_span   (o_span)
    );

endmodule

`default_nettype wire
